/* hw/rtl/wsts_pkg.sv */
// Shared types and constants for the weighted stump threshold search.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package wsts_pkg;

   localparam int MAX_SAMPLES = 256;
   localparam int VALUE_BITS  = 24;
   localparam int WEIGHT_BITS = 16;
   localparam int ERR_BITS    = 24;
   localparam int THR_BITS    = VALUE_BITS + 1;

   // One request: a labeled, weighted sample.
   typedef struct packed {
      logic signed [VALUE_BITS-1:0]  feature_value;
      logic                          is_positive;
      logic        [WEIGHT_BITS-1:0] sample_weight;
      logic                          last_sample;
   } req_type;

   // One result: chosen threshold and its weighted error.
   typedef struct packed {
      logic signed [THR_BITS-1:0] best_threshold;
      logic        [ERR_BITS-1:0] min_error;
   } rsp_type;

   // Sample as held in one chain cell.
   typedef struct packed {
      logic signed [VALUE_BITS-1:0]  value;
      logic                          label;
      logic        [WEIGHT_BITS-1:0] weight;
   } sample_type;

   typedef struct packed {
      logic       valid;
      sample_type smp;
   } entry_type;

   // Chain control: insert the broadcast sample, or shift everything to the head.
   typedef struct packed {
      logic insert;
      logic shift;
   } chain_ctrl_type;

   // Sweep control: load the starting error, or take one step over the head sample.
   typedef struct packed {
      logic load;
      logic step;
   } sweep_ctrl_type;

endpackage : wsts_pkg

`default_nettype wire

/* hw/rtl/wsts_cell.sv */
// One cell of the sorted sample chain: holds a sample and its valid bit.
// Depends on wsts_pkg.
`default_nettype none

module wsts_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  wsts_pkg::chain_ctrl_type   ctrl,
   input  wsts_pkg::sample_type       new_sample,
   input  wsts_pkg::entry_type        prev_entry,
   input  logic                       prev_moves,
   input  wsts_pkg::entry_type        next_entry,
   output wsts_pkg::entry_type        entry,
   output logic                       moves
);
   import wsts_pkg::*;

   logic       valid_ff, valid_in;
   sample_type data_ff, data_in;

   // The new sample belongs here or further toward the head: ties stay behind.
   assign moves = !valid_ff || (new_sample.value < data_ff.value);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.shift) begin
         valid_in = next_entry.valid;
         data_in  = next_entry.smp;
      end else if (ctrl.insert && moves) begin
         if (prev_moves) begin
            valid_in = prev_entry.valid;
            data_in  = prev_entry.smp;
         end else begin
            valid_in = 1'b1;
            data_in  = new_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry.valid = valid_ff;
   assign entry.smp   = data_ff;

endmodule : wsts_cell

`default_nettype wire

/* hw/rtl/wsts_chain.sv */
// Row of wsts_cell instances forming a sorted insertion chain.
// Depends on wsts_pkg and wsts_cell.
`default_nettype none

module wsts_chain (
   input  logic                      clock,
   input  logic                      reset,
   input  wsts_pkg::chain_ctrl_type  ctrl,
   input  wsts_pkg::sample_type      new_sample,
   output wsts_pkg::entry_type       head,
   output wsts_pkg::entry_type       second,
   output logic                      full
);
   import wsts_pkg::*;

   entry_type ent    [MAX_SAMPLES];
   logic      mv     [MAX_SAMPLES];
   entry_type prev_e [MAX_SAMPLES];
   logic      prev_m [MAX_SAMPLES];
   entry_type next_e [MAX_SAMPLES];

   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_e[i] = '0;
         assign prev_m[i] = 1'b0;
      end else begin : g_mid
         assign prev_e[i] = ent[i-1];
         assign prev_m[i] = mv[i-1];
      end
      if (i == MAX_SAMPLES - 1) begin : g_last
         assign next_e[i] = '0;
      end else begin : g_inner
         assign next_e[i] = ent[i+1];
      end

      wsts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_sample (new_sample),
         .prev_entry (prev_e[i]),
         .prev_moves (prev_m[i]),
         .next_entry (next_e[i]),
         .entry      (ent[i]),
         .moves      (mv[i])
      );
   end

   assign head   = ent[0];
   assign second = ent[1];
   assign full   = ent[MAX_SAMPLES-1].valid;

endmodule : wsts_chain

`default_nettype wire

/* hw/rtl/wsts_sweep.sv */
// Running-error sweep: tracks current and least error and the threshold.
// Depends on wsts_pkg.
`default_nettype none

module wsts_sweep (
   input  logic                      clock,
   input  wsts_pkg::sweep_ctrl_type  ctrl,
   input  logic [wsts_pkg::ERR_BITS-1:0] neg_sum,
   input  wsts_pkg::entry_type       head,
   input  wsts_pkg::entry_type       second,
   output wsts_pkg::rsp_type         result
);
   import wsts_pkg::*;

   logic        [ERR_BITS-1:0] cur_ff, cur_in, best_ff, best_in, step_err;
   logic signed [THR_BITS-1:0] thr_ff, thr_in;
   logic signed [THR_BITS-1:0] head_ext, next_ext, mid_sum, mid_adj, mid;

   assign head_ext = {head.smp.value[VALUE_BITS-1], head.smp.value};
   assign next_ext = {second.smp.value[VALUE_BITS-1], second.smp.value};

   // Midpoint truncated toward zero: bump odd negative sums before the shift.
   assign mid_sum = head_ext + next_ext;
   assign mid_adj = mid_sum + THR_BITS'(mid_sum[THR_BITS-1]);
   assign mid     = {mid_adj[THR_BITS-1], mid_adj[THR_BITS-1:1]};

   assign step_err = head.smp.label ? cur_ff + ERR_BITS'(head.smp.weight)
                                    : cur_ff - ERR_BITS'(head.smp.weight);

   always_comb begin
      cur_in  = cur_ff;
      best_in = best_ff;
      thr_in  = thr_ff;
      if (ctrl.load) begin
         cur_in  = neg_sum;
         best_in = neg_sum;
         thr_in  = head_ext - THR_BITS'(1);
      end else if (ctrl.step) begin
         cur_in = step_err;
         if (step_err < best_ff) begin
            best_in = step_err;
            thr_in  = second.valid ? mid : head_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      best_ff <= best_in;
      thr_ff  <= thr_in;
   end

   assign result.best_threshold = thr_ff;
   assign result.min_error      = best_ff;

endmodule : wsts_sweep

`default_nettype wire

/* hw/rtl/weighted_stump_threshold_search_top.sv */
// Top level of the weighted stump threshold search: control FSM, chain, sweep.
// Depends on wsts_pkg, wsts_chain (with wsts_cell) and wsts_sweep.
`default_nettype none

// Channel    Ports                      Direction  Handshake
// request    start, busy, req_data      in         accepted when start & !busy
// response   rsp_strobe, rsp_data       out        one-cycle strobe, no backpressure
//
// A request without last_sample is inserted into the sorted chain in the cycle
// it is accepted, unless the chain is full, and busy stays low.
// A request with last_sample is inserted, then busy rises for one load state,
// then one sweep step per stored sample, each step shifting the chain one cell
// toward the head. The result strobes in the cycle after the final step; the
// chain is empty by then.
// Reset clears the state, the cell valid bits and the negative-weight total.
// The receiver cannot stall: results are presented for exactly one cycle.

module weighted_stump_threshold_search_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wsts_pkg::req_type req_data,
   output logic              rsp_strobe,
   output wsts_pkg::rsp_type rsp_data
);
   import wsts_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [ERR_BITS-1:0] neg_sum_ff, neg_sum_in;
   logic                strobe_ff, strobe_in;

   logic           accept, take;
   logic           full;
   entry_type      head, second;
   sample_type     new_sample;
   chain_ctrl_type chain_ctrl;
   sweep_ctrl_type sweep_ctrl;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   // Drop the sample when the chain is full; a last flag still starts the search.
   assign take   = accept && !full;

   assign new_sample.value  = req_data.feature_value;
   assign new_sample.label  = req_data.is_positive;
   assign new_sample.weight = req_data.sample_weight;

   assign chain_ctrl.insert = take;
   assign chain_ctrl.shift  = (state_ff == ST_SWEEP);
   assign sweep_ctrl.load   = (state_ff == ST_LOAD);
   assign sweep_ctrl.step   = (state_ff == ST_SWEEP);

   always_comb begin
      state_in   = state_ff;
      neg_sum_in = neg_sum_ff;
      strobe_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Accumulate the starting error: total weight of negative samples.
            if (take && !req_data.is_positive) begin
               neg_sum_in = neg_sum_ff + ERR_BITS'(req_data.sample_weight);
            end
            if (accept && req_data.last_sample) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Hand the total to the sweep, clear it for the next data set.
            neg_sum_in = '0;
            state_in   = ST_SWEEP;
         end
         ST_SWEEP: begin
            // Finish when the head holds the last stored sample.
            if (!second.valid) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         neg_sum_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         neg_sum_ff <= neg_sum_in;
         strobe_ff  <= strobe_in;
      end
   end

   wsts_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (chain_ctrl),
      .new_sample (new_sample),
      .head       (head),
      .second     (second),
      .full       (full)
   );

   wsts_sweep u_sweep (
      .clock   (clock),
      .ctrl    (sweep_ctrl),
      .neg_sum (neg_sum_ff),
      .head    (head),
      .second  (second),
      .result  (rsp_data)
   );

   assign rsp_strobe = strobe_ff;

   // A result only follows the final sweep step.
   a_strobe_after_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_SWEEP)
      else $error("result strobe without a preceding sweep");

   // The sweep drains the chain completely.
   a_chain_empty_after: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !head.valid)
      else $error("chain not empty after result");

   // Every sweep step works on a stored sample.
   a_head_valid_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP |-> head.valid)
      else $error("sweep step on an empty head cell");

   // A last request always starts the search.
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_sample |=> state_ff == ST_LOAD)
      else $error("last request did not start the search");

endmodule : weighted_stump_threshold_search_top

`default_nettype wire
